// ===== rtl/bmrs_pkg.sv =====
// Shared types and constants of the block-mapped read splitter.
`default_nettype none
package bmrs_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK,
        S_CHECK,
        S_DECIDE,
        S_SEG
    } state_t;

    // Result status codes
    localparam logic [1:0] ST_SEG   = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_MANY  = 2'd2;
    localparam logic [1:0] ST_ACK   = 2'd3;

    // Function codes of an input word
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_LOG2   = 1'b0;
    localparam logic REG_STREAM = 1'b1;

    // Block size limits and reset value
    localparam logic [4:0] LOG2_MIN = 5'd6;
    localparam logic [4:0] LOG2_MAX = 5'd16;
    localparam logic [4:0] LOG2_RST = 5'd12;

    // A read may span at most this many blocks
    localparam logic [31:0] SEG_LIMIT = 32'd64;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [4:0]  blk_log2;     // clamped to LOG2_MIN..LOG2_MAX
        logic [31:0] stream_size;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/bmrs_cfg.sv =====
// APB register file: block size and stream size.
`default_nettype none
module bmrs_cfg
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output bmrs_pkg::cfg_t     cfg
);

    logic [4:0]  log2_reg;
    logic [31:0] stream_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg   <= bmrs_pkg::LOG2_RST;
            stream_reg <= 32'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                bmrs_pkg::REG_LOG2:   log2_reg   <= pwdata[4:0];
                bmrs_pkg::REG_STREAM: stream_reg <= pwdata;
                default:              stream_reg <= pwdata;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (paddr[2])
            bmrs_pkg::REG_LOG2:   prdata = {27'd0, log2_reg};
            bmrs_pkg::REG_STREAM: prdata = stream_reg;
            default:              prdata = 32'd0;
        endcase
    end

    // clamp block size into its legal range
    always_comb
    begin
        cfg.stream_size = stream_reg;
        if (log2_reg < bmrs_pkg::LOG2_MIN)
            cfg.blk_log2 = bmrs_pkg::LOG2_MIN;
        else if (log2_reg > bmrs_pkg::LOG2_MAX)
            cfg.blk_log2 = bmrs_pkg::LOG2_MAX;
        else
            cfg.blk_log2 = log2_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/bmrs_table.sv =====
// Block table memory: one write port, one registered read port.
`default_nettype none
module bmrs_table
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/bmrs_ctrl.sv =====
// Sequencer: range checks, segment splitting and result register.
`default_nettype none
module bmrs_ctrl
#(
    parameter int MAX_BLOCKS = 4096,
    parameter int IDX_W      = 12
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bmrs_pkg::cfg_t   cfg,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             func,
    input  wire logic [11:0]      entry_index,
    input  wire logic [31:0]      entry_block,
    input  wire logic [31:0]      stream_offset,
    input  wire logic [31:0]      read_length,
    output logic                  mem_we,
    output logic      [IDX_W-1:0] mem_waddr,
    output logic      [31:0]      mem_wdata,
    output logic                  mem_re,
    output logic      [IDX_W-1:0] mem_raddr,
    input  wire logic [31:0]      mem_rdata,
    output logic                  result_valid,
    output logic      [47:0]      src_addr,
    output logic      [31:0]      dst_offset,
    output logic      [16:0]      seg_length,
    output logic      [1:0]       status,
    output logic                  last
);

    localparam logic [31:0] MAX32 = 32'(MAX_BLOCKS);
    localparam logic [16:0] MAX17 = 17'(MAX_BLOCKS);

    bmrs_pkg::state_t state_reg, state_next;

    // latched item
    logic [11:0] idx_reg;
    logic [31:0] eblk_reg;
    logic [31:0] off_reg;
    logic [31:0] len_reg;
    logic [4:0]  l_reg;
    logic [32:0] end_reg;
    logic [32:0] endm1_reg;

    // check results
    logic [31:0] first_reg;
    logic [31:0] lastb_reg;
    logic        over_stream_reg;

    // segment walk
    logic [IDX_W-1:0] blk_reg;
    logic [15:0]      within_reg;
    logic [31:0]      remain_reg;
    logic [31:0]      done_reg;
    logic             zsrc_reg;

    // table read stage
    logic        p1_valid_reg;
    logic [15:0] p1_within_reg;
    logic [16:0] p1_seg_reg;
    logic [31:0] p1_dst_reg;
    logic        p1_last_reg;
    logic        p1_zsrc_reg;

    // result register
    logic        result_valid_reg;
    logic [47:0] src_reg;
    logic [31:0] dst_reg;
    logic [16:0] seglen_reg;
    logic [1:0]  status_reg;
    logic        last_reg;

    logic        accept;
    logic        idx_ok;
    logic [16:0] bsize;
    logic [16:0] bsize_m1;
    logic [16:0] room;
    logic        seg_last;
    logic [16:0] seg_len;
    logic [31:0] span;
    logic        zero_len;
    logic        dec_err;
    logic [1:0]  dec_status;
    logic [47:0] shifted;
    logic [47:0] src_calc;

    assign accept   = start && (state_reg == bmrs_pkg::S_IDLE);
    assign idx_ok   = {5'd0, idx_reg} < MAX17;
    assign bsize    = 17'd1 << l_reg;
    assign bsize_m1 = bsize - 17'd1;

    // segment size: up to the block end or the rest of the read
    assign room     = bsize - {1'b0, within_reg};
    assign seg_last = remain_reg <= {15'd0, room};
    assign seg_len  = seg_last ? remain_reg[16:0] : room;

    // range and span decision
    assign span     = lastb_reg - first_reg;
    assign zero_len = (len_reg == 32'd0);

    always_comb
    begin
        dec_err    = 1'b0;
        dec_status = bmrs_pkg::ST_SEG;
        if (over_stream_reg)
        begin
            dec_err    = 1'b1;
            dec_status = bmrs_pkg::ST_RANGE;
        end
        else if (!zero_len)
        begin
            if (lastb_reg >= MAX32)
            begin
                dec_err    = 1'b1;
                dec_status = bmrs_pkg::ST_RANGE;
            end
            else if (span >= bmrs_pkg::SEG_LIMIT)
            begin
                dec_err    = 1'b1;
                dec_status = bmrs_pkg::ST_MANY;
            end
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bmrs_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmrs_pkg::S_IDLE:
            begin
                if (start)
                    state_next = (func == bmrs_pkg::FUNC_LOAD) ? bmrs_pkg::S_ACK
                                                               : bmrs_pkg::S_CHECK;
            end
            bmrs_pkg::S_ACK:    state_next = bmrs_pkg::S_IDLE;
            bmrs_pkg::S_CHECK:  state_next = bmrs_pkg::S_DECIDE;
            bmrs_pkg::S_DECIDE: state_next = dec_err ? bmrs_pkg::S_IDLE : bmrs_pkg::S_SEG;
            bmrs_pkg::S_SEG:
            begin
                if (seg_last)
                    state_next = bmrs_pkg::S_IDLE;
            end
            default:            state_next = bmrs_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy   = 1'b1;
        mem_we = 1'b0;
        mem_re = 1'b0;
        unique case (state_reg)
            bmrs_pkg::S_IDLE: busy   = 1'b0;
            bmrs_pkg::S_ACK:  mem_we = idx_ok;
            bmrs_pkg::S_SEG:  mem_re = !zsrc_reg;
            default:          busy   = 1'b1;
        endcase
    end

    assign mem_waddr = IDX_W'(idx_reg);

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= entry_index;
            eblk_reg  <= entry_block;
            off_reg   <= stream_offset;
            len_reg   <= read_length;
            l_reg     <= cfg.blk_log2;
            end_reg   <= {1'b0, stream_offset} + {1'b0, read_length};
            endm1_reg <= {1'b0, stream_offset} + {1'b0, read_length} - 33'd1;
        end
        if (state_reg == bmrs_pkg::S_CHECK)
        begin
            over_stream_reg <= end_reg > {1'b0, cfg.stream_size};
            first_reg       <= off_reg >> l_reg;
            lastb_reg       <= endm1_reg[31:0] >> l_reg;
        end
        if (state_reg == bmrs_pkg::S_DECIDE)
        begin
            blk_reg    <= first_reg[IDX_W-1:0];
            within_reg <= off_reg[15:0] & bsize_m1[15:0];
            remain_reg <= len_reg;
            done_reg   <= 32'd0;
            zsrc_reg   <= first_reg >= MAX32;
        end
        if (state_reg == bmrs_pkg::S_SEG)
        begin
            blk_reg    <= blk_reg + IDX_W'(1);
            within_reg <= 16'd0;
            remain_reg <= remain_reg - {15'd0, seg_len};
            done_reg   <= done_reg + {15'd0, seg_len};
        end
        // table read stage
        p1_within_reg <= within_reg;
        p1_seg_reg    <= seg_len;
        p1_dst_reg    <= done_reg;
        p1_last_reg   <= seg_last;
        p1_zsrc_reg   <= zsrc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= (state_reg == bmrs_pkg::S_SEG);
    end

    // physical address of a segment
    assign shifted  = {16'd0, mem_rdata} << l_reg;
    assign src_calc = p1_zsrc_reg ? 48'd0 : shifted + {32'd0, p1_within_reg};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= p1_valid_reg || (state_reg == bmrs_pkg::S_ACK)
                                || ((state_reg == bmrs_pkg::S_DECIDE) && dec_err);
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            src_reg    <= src_calc;
            dst_reg    <= p1_dst_reg;
            seglen_reg <= p1_seg_reg;
            status_reg <= bmrs_pkg::ST_SEG;
            last_reg   <= p1_last_reg;
        end
        else if (state_reg == bmrs_pkg::S_ACK)
        begin
            src_reg    <= 48'd0;
            dst_reg    <= 32'd0;
            seglen_reg <= 17'd0;
            status_reg <= idx_ok ? bmrs_pkg::ST_ACK : bmrs_pkg::ST_RANGE;
            last_reg   <= 1'b1;
        end
        else if (state_reg == bmrs_pkg::S_DECIDE)
        begin
            src_reg    <= 48'd0;
            dst_reg    <= 32'd0;
            seglen_reg <= 17'd0;
            status_reg <= dec_status;
            last_reg   <= 1'b1;
        end
    end

    assign mem_raddr    = blk_reg;
    assign mem_wdata    = eblk_reg;
    assign result_valid = result_valid_reg;
    assign src_addr     = src_reg;
    assign dst_offset   = dst_reg;
    assign seg_length   = seglen_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

// ===== rtl/block_mapped_read_splitter.sv =====
// Top level of the block-mapped read splitter.
//
// A load word (func 0) gives one acknowledge result. A read word (func 1) gives
// one result per segment: the start cycle forms the range end, S_CHECK shifts
// offsets into block numbers, S_DECIDE decides on range and span, then S_SEG
// uses the single table read port once per segment (not past the table); each
// segment result passes the table read stage and the result register. A rejected
// read gives one result from S_DECIDE. busy is high while a word is in work;
// results appear for one cycle on result_valid and cannot be held off, and a new
// word may be started while the previous final result is still on the ports.
`default_nettype none
module block_mapped_read_splitter
#(
    parameter int MAX_BLOCKS = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        func,
    input  wire logic [11:0] entry_index,
    input  wire logic [31:0] entry_block,
    input  wire logic [31:0] stream_offset,
    input  wire logic [31:0] read_length,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic             result_valid,
    output logic      [47:0] src_addr,
    output logic      [31:0] dst_offset,
    output logic      [16:0] seg_length,
    output logic      [1:0]  status,
    output logic             last
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    bmrs_pkg::cfg_t   cfg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [31:0]      mem_rdata;

    bmrs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmrs_table #(.DEPTH(MAX_BLOCKS), .AW(IDX_W)) u_table
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bmrs_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .IDX_W(IDX_W)) u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .entry_index   (entry_index),
        .entry_block   (entry_block),
        .stream_offset (stream_offset),
        .read_length   (read_length),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .result_valid  (result_valid),
        .src_addr      (src_addr),
        .dst_offset    (dst_offset),
        .seg_length    (seg_length),
        .status        (status),
        .last          (last)
    );

    // an accepted word keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start");

    // non-final segments come back to back
    a_seg_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("gap inside a segment burst");

    // destination offsets advance by the previous segment length
    a_dst_advance: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=>
            dst_offset == $past(dst_offset) + {15'd0, $past(seg_length)})
        else $error("destination offset out of step");

    // acknowledge and error results are single and empty
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != bmrs_pkg::ST_SEG) |-> last && (seg_length == 17'd0))
        else $error("non-segment result malformed");

endmodule
`default_nettype wire

// ===== tb/bmrs_scoreboard_pkg.sv =====
// Word types and the segment scoreboard (table mirror, predictor, result check).
`timescale 1ns / 100ps
package bmrs_scoreboard_pkg;
    import bmrs_pkg::*;

    localparam int unsigned MAP_DEPTH = 4096;

    // One input word as the driver hands it over
    typedef struct packed {
        logic        func;
        logic [11:0] entry_index;
        logic [31:0] entry_block;
        logic [31:0] stream_offset;
        logic [31:0] read_length;
    } req_word_t;

    // One result word
    typedef struct packed {
        logic [47:0] src_addr;
        logic [31:0] dst_offset;
        logic [16:0] seg_length;
        logic [1:0]  status;
        logic        last;
    } seg_word_t;

    class segment_ledger;
        logic [31:0] phys_map [MAP_DEPTH];
        bit          mapped [MAP_DEPTH];
        logic [4:0]  log2_reg;
        logic [31:0] stream_reg;
        seg_word_t   due_segs [$];
        int unsigned fails;

        function new();
            log2_reg   = LOG2_RST;
            stream_reg = '0;
            fails      = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == REG_LOG2)
                log2_reg = val[4:0];
            else
                stream_reg = val;
        endfunction

        // Block size in use: out-of-range settings are clamped
        function int unsigned eff_log2();
            if (log2_reg < LOG2_MIN)
                return LOG2_MIN;
            if (log2_reg > LOG2_MAX)
                return LOG2_MAX;
            return log2_reg;
        endfunction

        function logic [47:0] phys_addr(int unsigned blk, longint unsigned in_blk);
            longint unsigned a;
            a = ({32'd0, phys_map[blk]} << eff_log2()) + in_blk;
            return a[47:0];
        endfunction

        // Range and span checks of a read. ST_SEG means the table is looked up
        // for cnt blocks starting at first (cnt is 0 for an empty read past the table).
        function logic [1:0] read_span(input logic [31:0] off, input logic [31:0] len,
                                       output int unsigned first, output int unsigned cnt);
            longint unsigned fin;
            longint unsigned lastb;
            fin   = {32'd0, off} + {32'd0, len};
            first = off >> eff_log2();
            cnt   = 0;
            if (fin > {32'd0, stream_reg})
                return ST_RANGE;
            if (len == 0)
            begin
                cnt = (first < MAP_DEPTH) ? 1 : 0;
                return ST_SEG;
            end
            lastb = (fin - 1) >> eff_log2();
            if (lastb >= MAP_DEPTH)
                return ST_RANGE;
            cnt = lastb - first + 1;
            if (cnt > SEG_LIMIT)
                return ST_MANY;
            return ST_SEG;
        endfunction

        // True when the read never looks up an entry that was not loaded
        function bit read_is_safe(logic [31:0] off, logic [31:0] len);
            int unsigned first;
            int unsigned cnt;
            if (read_span(off, len, first, cnt) != ST_SEG)
                return 1;
            for (int unsigned b = first; b < first + cnt; b++)
                if (!mapped[b])
                    return 0;
            return 1;
        endfunction

        // Accepted input word: update the mirror and queue the expected results
        function void note_word(req_word_t w);
            int unsigned     first;
            int unsigned     cnt;
            int unsigned     l;
            logic [1:0]      st;
            longint unsigned bsz;
            longint unsigned pos;
            longint unsigned done;
            longint unsigned in_blk;
            longint unsigned seg;
            l   = eff_log2();
            bsz = 64'd1 << l;
            if (w.func == FUNC_LOAD)
            begin
                phys_map[w.entry_index] = w.entry_block;
                mapped[w.entry_index]   = 1'b1;
                due_segs.push_back('{48'd0, 32'd0, 17'd0, ST_ACK, 1'b1});
                return;
            end
            st = read_span(w.stream_offset, w.read_length, first, cnt);
            if (st != ST_SEG)
                due_segs.push_back('{48'd0, 32'd0, 17'd0, st, 1'b1});
            else if (w.read_length == 0)
                due_segs.push_back('{(cnt != 0) ? phys_addr(first, w.stream_offset & (bsz - 1))
                                                : 48'd0,
                                     32'd0, 17'd0, ST_SEG, 1'b1});
            else
            begin
                // cut at block boundaries
                pos  = w.stream_offset;
                done = 0;
                for (int unsigned k = 0; k < cnt; k++)
                begin
                    in_blk = pos & (bsz - 1);
                    seg    = bsz - in_blk;
                    if (w.read_length - done < seg)
                        seg = w.read_length - done;
                    due_segs.push_back('{phys_addr(pos >> l, in_blk), done[31:0], seg[16:0],
                                         ST_SEG, k == cnt - 1});
                    done += seg;
                    pos  += seg;
                end
            end
        endfunction

        function void compare(string fld, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
                fails++;
            end
        endfunction

        // Result word seen on the ports: check against the oldest expectation
        function void check_segment(seg_word_t got);
            seg_word_t want;
            if (due_segs.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d src_addr %h",
                         $time, got.status, got.src_addr);
                fails++;
                return;
            end
            want = due_segs.pop_front();
            compare("src_addr", want.src_addr, got.src_addr);
            compare("dst_offset", want.dst_offset, got.dst_offset);
            compare("seg_length", want.seg_length, got.seg_length);
            compare("status", want.status, got.status);
            compare("last", want.last, got.last);
        endfunction
    endclass

endpackage

// ===== tb/block_mapped_read_splitter_test.sv =====
// Top-level testbench of the block-mapped read splitter.
`timescale 1ns / 100ps
module block_mapped_read_splitter_test;
    import bmrs_pkg::*;
    import bmrs_scoreboard_pkg::*;

    localparam int unsigned WIN_LAST    = 69;
    localparam int unsigned TOP_FIRST   = MAP_DEPTH - 6;
    localparam int unsigned RAND_PHASES = 6;
    localparam int unsigned PHASE_WORDS = 16;
    localparam int unsigned LOG2_PICK [RAND_PHASES] = '{6, 16, 9, 31, 2, 12};
    localparam int unsigned IDLE_PICK [RAND_PHASES] = '{35, 0, 50, 20, 35, 0};

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic        func          = 1'b0;
    logic [11:0] entry_index   = '0;
    logic [31:0] entry_block   = '0;
    logic [31:0] stream_offset = '0;
    logic [31:0] read_length   = '0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        result_valid;
    logic [47:0] src_addr;
    logic [31:0] dst_offset;
    logic [16:0] seg_length;
    logic [1:0]  status;
    logic        last;

    segment_ledger ledger;
    int unsigned   idle_pct = 30;

    always #10 clk = ~clk;

    block_mapped_read_splitter u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .entry_index   (entry_index),
        .entry_block   (entry_block),
        .stream_offset (stream_offset),
        .read_length   (read_length),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .result_valid  (result_valid),
        .src_addr      (src_addr),
        .dst_offset    (dst_offset),
        .seg_length    (seg_length),
        .status        (status),
        .last          (last)
    );

    // Result monitor: every strobed word is taken
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            ledger.check_segment({src_addr, dst_offset, seg_length, status, last});
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("block_mapped_read_splitter_test failed");
        $finish;
    end

    // Present a word and hold it until the block takes it
    task automatic send_word(input req_word_t w);
        func          <= w.func;
        entry_index   <= w.entry_index;
        entry_block   <= w.entry_block;
        stream_offset <= w.stream_offset;
        read_length   <= w.read_length;
        start         <= 1'b1;
        do @(posedge clk); while (busy);
        ledger.note_word(w);
    endtask

    task automatic idle_gap();
        if ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clk);
        end
    endtask

    // Read fields of a load word carry noise
    task automatic load_entry(input int unsigned idx, input logic [31:0] blk);
        req_word_t w;
        w.func          = FUNC_LOAD;
        w.entry_index   = idx[11:0];
        w.entry_block   = blk;
        w.stream_offset = $urandom;
        w.read_length   = $urandom;
        send_word(w);
        idle_gap();
    endtask

    // Load fields of a read word carry noise
    task automatic read_range(input logic [31:0] off, input logic [31:0] len);
        req_word_t w;
        w.func          = FUNC_READ;
        w.entry_index   = $urandom;
        w.entry_block   = $urandom;
        w.stream_offset = off;
        w.read_length   = len;
        send_word(w);
        idle_gap();
    endtask

    // Drain all expected results and let the block go idle
    task automatic settle();
        start <= 1'b0;
        while (ledger.due_segs.size() != 0)
            @(posedge clk);
        do @(posedge clk); while (busy);
        repeat (4) @(posedge clk);
    endtask

    // Setup then access cycle
    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.set_reg(idx, val);
    endtask

    // Mostly reads over mapped runs, some loads, some out-of-range noise
    task automatic random_word();
        int unsigned pick;
        int unsigned l;
        int unsigned bsz;
        int unsigned first;
        int unsigned run;
        int unsigned c;
        int unsigned w;
        logic [31:0] off;
        logic [31:0] len;
        l    = ledger.eff_log2();
        bsz  = 1 << l;
        pick = $urandom_range(99, 0);
        if (pick < 20)
        begin
            load_entry((pick < 8) ? $urandom_range(MAP_DEPTH - 1, 0) : $urandom_range(WIN_LAST, 0),
                       $urandom);
            return;
        end
        if (pick < 85)
        begin
            first = ($urandom_range(3, 0) == 0) ? $urandom_range(MAP_DEPTH - 1, TOP_FIRST)
                                                : $urandom_range(WIN_LAST, 0);
            run = 0;
            while (run < SEG_LIMIT && first + run < MAP_DEPTH && ledger.mapped[first + run])
                run++;
            if (run == 0)
            begin
                load_entry(first, $urandom);
                return;
            end
            c   = ($urandom_range(3, 0) == 0) ? $urandom_range(run, 1)
                                              : $urandom_range((run < 3) ? run : 3, 1);
            w   = $urandom_range(bsz - 1, 0);
            off = (first << l) + w;
            // length chosen so the read ends in block first + c - 1
            if ($urandom_range(19, 0) == 0)
                len = 0;
            else
                len = $urandom_range(c * bsz - w, (c == 1) ? 1 : (c - 1) * bsz - w + 1);
            read_range(off, len);
            return;
        end
        do
        begin
            case ($urandom_range(2, 0))
                0:
                begin
                    off = $urandom;
                    len = $urandom;
                end
                1:
                begin
                    off = $urandom;
                    len = $urandom_range(4 * bsz, 0);
                end
                default:
                begin
                    off = ledger.stream_reg - $urandom_range(bsz, 0);
                    len = $urandom_range(2 * bsz, 0);
                end
            endcase
        end
        while (!ledger.read_is_safe(off, len));
        read_range(off, len);
    endtask

    initial
    begin
        int unsigned n;
        ledger = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 4 KiB blocks, empty stream
        load_entry(0, 32'd0);
        load_entry(MAP_DEPTH - 1, 32'hFFFF_FFFF);
        read_range(0, 0);
        read_range(0, 1);

        // Block size below range, whole 32-bit stream
        settle();
        write_reg(REG_LOG2, 32'd0);
        write_reg(REG_STREAM, 32'hFFFF_FFFF);
        load_entry(1, 32'd5);
        read_range(32'h3F, 2);
        read_range(32'hFFFF_FFFF, 1);                  // end needs a 33rd bit
        read_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        read_range(MAP_DEPTH * 64, 0);                 // empty read beyond the table
        read_range((MAP_DEPTH - 1) * 64 + 63, 1);      // last byte of the table
        read_range((MAP_DEPTH - 1) * 64, 65);          // one byte past the table
        read_range(0, 65 * 64);                        // one block too many
        read_range(1, 64 * 64);                        // same, unaligned

        // Block size above range, stream of one block
        settle();
        write_reg(REG_LOG2, 32'd31);
        write_reg(REG_STREAM, 32'h1_0000);
        read_range(0, 32'h1_0000);                     // full block
        read_range(0, 32'h1_0001);
        read_range(32'hFFFF, 1);
        read_range(32'h1_0000, 0);                     // empty read at stream end
        load_entry(0, 32'hFFFF_FFFF);
        read_range(32'h8000, 32'h8000);

        // Random phases, each under its own settings
        for (int unsigned p = 0; p < RAND_PHASES; p++)
        begin
            settle();
            write_reg(REG_LOG2, LOG2_PICK[p]);
            write_reg(REG_STREAM, (p % 2 == 0) ? 32'hFFFF_FFFF
                : $urandom_range(70 << ledger.eff_log2(), 8 << ledger.eff_log2()));
            idle_pct = IDLE_PICK[p];
            if (p == 0)
            begin
                // map a window at each end of the table
                for (int unsigned b = 0; b <= WIN_LAST; b++)
                    load_entry(b, $urandom);
                for (int unsigned b = TOP_FIRST; b < MAP_DEPTH; b++)
                    load_entry(b, $urandom);
            end
            repeat (PHASE_WORDS) random_word();
        end

        // Drain and finish
        start <= 1'b0;
        n = 0;
        while (ledger.due_segs.size() != 0 && n < 5000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (80) @(posedge clk);
        if (ledger.due_segs.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, ledger.due_segs.size());
        if (ledger.fails == 0 && ledger.due_segs.size() == 0)
            $display("block_mapped_read_splitter_test passed");
        else
            $display("block_mapped_read_splitter_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bmrs_pkg.sv
rtl/bmrs_cfg.sv
rtl/bmrs_table.sv
rtl/bmrs_ctrl.sv
rtl/block_mapped_read_splitter.sv
tb/bmrs_scoreboard_pkg.sv
tb/block_mapped_read_splitter_test.sv
